// File: rtl/tcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types, constants and the exponential table for the thumbstick
// cursor delta pipeline.
// ----------------------------------------------------------------------------
package tcd_pkg;

    localparam int UPDATE_RATE = 60;

    // Step clamp before the rate division: beyond this every step saturates.
    localparam longint PMAX = longint'(UPDATE_RATE) * 32769;
    localparam int PW = $clog2(PMAX + 1);
    localparam int RSH = PW + 1;
    localparam longint RECIP = (64'd1 << RSH) / UPDATE_RATE;
    localparam int PRW = 2 * PW + 1;

    // Stage numbering
    localparam int ST_SEL     = 0;
    localparam int ST_SUM     = 1;
    localparam int SQRT_N     = 24;
    localparam int ST_SQRT0   = 2;
    localparam int ST_DIVINIT = ST_SQRT0 + SQRT_N;
    localparam int DIV_N      = 16;
    localparam int ST_DIV0    = ST_DIVINIT + 1;
    localparam int ST_LOOKUP  = ST_DIV0 + DIV_N;
    localparam int ST_CURVE   = ST_LOOKUP + 1;
    localparam int ST_SPEED   = ST_CURVE + 1;
    localparam int ST_BOOST   = ST_SPEED + 1;
    localparam int ST_PPROD   = ST_BOOST + 1;
    localparam int ST_PSUM    = ST_PPROD + 1;
    localparam int ST_RECIP   = ST_PSUM + 1;
    localparam int ST_CORR    = ST_RECIP + 1;
    localparam int ST_SAT     = ST_CORR + 1;
    localparam int NST        = ST_SAT + 1;

    typedef enum logic [1:0] {
        CFG_DEAD_ZONE    = 2'd0,
        CFG_CURSOR_SPEED = 2'd1,
        CFG_BOOST_FACTOR = 2'd2,
        CFG_SWAP_STICKS  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic          neg_x;
        logic          neg_y;
        logic          boost;
        logic          dead;
        logic          capped;
        logic [16:0]   mag_x;
        logic [16:0]   mag_y;
        logic [30:0]   sq_x;
        logic [30:0]   sq_y;
        logic [31:0]   lsq;
        logic [47:0]   srem;
        logic [23:0]   root;
        logic [24:0]   drem;
        logic [15:0]   quo;
        logic [16:0]   m;
        logic [16:0]   e0;
        logic [15:0]   diff;
        logic [10:0]   frac;
        logic [16:0]   curve;
        logic [32:0]   cs;
        logic [48:0]   scale;
        logic [41:0]   plo_x;
        logic [41:0]   plo_y;
        logic [40:0]   phi_x;
        logic [40:0]   phi_y;
        logic [PW-1:0] pc_x;
        logic [PW-1:0] pc_y;
        logic [16:0]   q_x;
        logic [16:0]   q_y;
        logic [15:0]   out_x;
        logic [15:0]   out_y;
    } pipe_t;

    // exp(5m - 5) in Q0.16 sampled at m = i/32
    function automatic logic [16:0] exp_tab(input logic [5:0] i);
        logic [16:0] v;
        case (i)
            6'd0:  v = 17'd442;
            6'd1:  v = 17'd516;
            6'd2:  v = 17'd604;
            6'd3:  v = 17'd706;
            6'd4:  v = 17'd825;
            6'd5:  v = 17'd964;
            6'd6:  v = 17'd1128;
            6'd7:  v = 17'd1318;
            6'd8:  v = 17'd1541;
            6'd9:  v = 17'd1802;
            6'd10: v = 17'd2107;
            6'd11: v = 17'd2463;
            6'd12: v = 17'd2879;
            6'd13: v = 17'd3366;
            6'd14: v = 17'd3936;
            6'd15: v = 17'd4601;
            6'd16: v = 17'd5379;
            6'd17: v = 17'd6289;
            6'd18: v = 17'd7353;
            6'd19: v = 17'd8596;
            6'd20: v = 17'd10050;
            6'd21: v = 17'd11750;
            6'd22: v = 17'd13737;
            6'd23: v = 17'd16060;
            6'd24: v = 17'd18776;
            6'd25: v = 17'd21952;
            6'd26: v = 17'd25664;
            6'd27: v = 17'd30004;
            6'd28: v = 17'd35079;
            6'd29: v = 17'd41011;
            6'd30: v = 17'd47947;
            6'd31: v = 17'd56056;
            6'd32: v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    localparam logic [16:0] E_BASE = 17'd442;

endpackage
`default_nettype wire

// File: rtl/thumbstick_cursor_delta_top.sv
`default_nettype none
// Throughput: one item per cycle unless m_tready stalls the output; bit-serial square root
// and divider stages each resolve one bit, so an unstalled stage is free again in the next cycle.
// Reset: synchronous active-low aresetn empties the pipeline and loads the
// register defaults (dead zone 6000, speed 328, boost 256, left stick).
// ----------------------------------------------------------------------------
// thumbstick_cursor_delta_top
// Radial dead zone, exponential response curve and scaling of one stick
// sample into a saturated cursor step, fully pipelined.
// ----------------------------------------------------------------------------
module thumbstick_cursor_delta_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // left_x, left_y, right_x, right_y
    input  wire logic        s_tuser,   // boost
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // move_x, move_y
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int NST = tcd_pkg::NST;
    localparam int PW  = tcd_pkg::PW;
    localparam int PRW = tcd_pkg::PRW;

    logic [14:0] dz_reg;
    logic [15:0] speed_reg;
    logic [15:0] boostf_reg;
    logic        swap_reg;

    tcd_pkg::pipe_t pipe_reg  [NST];
    tcd_pkg::pipe_t pipe_next [NST];
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_reg     <= 15'd6000;
            speed_reg  <= 16'd328;
            boostf_reg <= 16'd256;
            swap_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (tcd_pkg::cfg_idx_t'(cfg_index))
                tcd_pkg::CFG_DEAD_ZONE:    dz_reg     <= cfg_data[14:0];
                tcd_pkg::CFG_CURSOR_SPEED: speed_reg  <= cfg_data;
                tcd_pkg::CFG_BOOST_FACTOR: boostf_reg <= cfg_data;
                tcd_pkg::CFG_SWAP_STICKS:  swap_reg   <= cfg_data[0];
            endcase
        end
    end

    // stage k advances when empty or when its successor advances
    always_comb begin
        adv[NST-1] = !valid_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0];

    always_comb begin
        tcd_pkg::pipe_t   p;
        logic [15:0]      sx, sy;
        logic [22:0]      den;
        logic [23:0]      num;
        logic [48:0]      t;
        logic [24:0]      t2;
        logic [5:0]       idx;
        logic [16:0]      e;
        logic [15:0]      b;
        logic [65:0]      sum_x, sum_y;
        logic [PRW-1:0]   prod_x, prod_y;
        logic [PW:0]      r_x, r_y;
        int               j;
        p      = '0;
        sx     = '0;
        sy     = '0;
        num    = '0;
        t      = '0;
        t2     = '0;
        idx    = '0;
        e      = '0;
        b      = '0;
        sum_x  = '0;
        sum_y  = '0;
        prod_x = '0;
        prod_y = '0;
        r_x    = '0;
        r_y    = '0;
        j      = 0;
        den = {15'd32767 - dz_reg, 8'd0};
        for (int k = 0; k < NST; k++) begin
            p = (k == 0) ? '0 : pipe_reg[(k == 0) ? 0 : k - 1];
            if (k == tcd_pkg::ST_SEL) begin
                sx = swap_reg ? s_tdata[47:32] : s_tdata[15:0];
                sy = swap_reg ? s_tdata[63:48] : s_tdata[31:16];
                p.mag_x = sx[15] ? 17'(17'h10000 - {1'b0, sx}) : {1'b0, sx};
                p.mag_y = sy[15] ? 17'(17'h10000 - {1'b0, sy}) : {1'b0, sy};
                p.neg_x = sx[15];
                p.neg_y = !sy[15];
                p.boost = s_tuser;
                p.sq_x  = 31'(34'(p.mag_x) * 34'(p.mag_x));
                p.sq_y  = 31'(34'(p.mag_y) * 34'(p.mag_y));
            end else if (k == tcd_pkg::ST_SUM) begin
                p.lsq  = 32'(p.sq_x) + 32'(p.sq_y);
                p.dead = p.lsq <= 32'(30'(dz_reg) * 30'(dz_reg));
                p.srem = {p.lsq, 16'd0};
                p.root = '0;
            end else if (k < tcd_pkg::ST_DIVINIT) begin
                j = tcd_pkg::ST_DIVINIT - 1 - k;
                t = (49'(p.root) << (j + 1)) + (49'd1 << (2 * j));
                if (49'(p.srem) >= t) begin
                    p.srem = 48'(49'(p.srem) - t);
                    p.root = p.root | (24'd1 << j);
                end
            end else if (k == tcd_pkg::ST_DIVINIT) begin
                num      = p.root - 24'({dz_reg, 8'd0});
                p.capped = num >= 24'(den);
                p.drem   = 25'(num);
                p.quo    = '0;
            end else if (k < tcd_pkg::ST_LOOKUP) begin
                t2 = p.drem << 1;
                if (t2 >= 25'(den)) begin
                    p.drem = t2 - 25'(den);
                    p.quo  = {p.quo[14:0], 1'b1};
                end else begin
                    p.drem = t2;
                    p.quo  = {p.quo[14:0], 1'b0};
                end
            end else if (k == tcd_pkg::ST_LOOKUP) begin
                p.m    = p.capped ? 17'h10000 : {1'b0, p.quo};
                idx    = p.m[16:11];
                p.e0   = tcd_pkg::exp_tab(idx);
                p.diff = (idx == 6'd32) ? 16'd0
                                        : 16'(tcd_pkg::exp_tab(idx + 6'd1) - p.e0);
                p.frac = p.m[10:0];
            end else if (k == tcd_pkg::ST_CURVE) begin
                e       = p.e0 + 17'((27'(p.diff) * 27'(p.frac)) >> 11);
                p.curve = 17'(p.m >> 2) + e - tcd_pkg::E_BASE;
            end else if (k == tcd_pkg::ST_SPEED) begin
                p.cs = 33'(33'(p.curve) * 33'(speed_reg));
            end else if (k == tcd_pkg::ST_BOOST) begin
                b       = (p.boost && boostf_reg != 16'd0) ? boostf_reg : 16'd256;
                p.scale = 49'(49'(p.cs) * 49'(b));
            end else if (k == tcd_pkg::ST_PPROD) begin
                p.plo_x = 42'(42'(p.mag_x) * 42'(p.scale[24:0]));
                p.plo_y = 42'(42'(p.mag_y) * 42'(p.scale[24:0]));
                p.phi_x = 41'(41'(p.mag_x) * 41'(p.scale[48:25]));
                p.phi_y = 41'(41'(p.mag_y) * 41'(p.scale[48:25]));
            end else if (k == tcd_pkg::ST_PSUM) begin
                sum_x  = (66'(p.phi_x) << 25) + 66'(p.plo_x);
                sum_y  = (66'(p.phi_y) << 25) + 66'(p.plo_y);
                p.pc_x = (sum_x[65:40] > 26'(tcd_pkg::PMAX)) ? PW'(tcd_pkg::PMAX)
                                                              : PW'(sum_x[65:40]);
                p.pc_y = (sum_y[65:40] > 26'(tcd_pkg::PMAX)) ? PW'(tcd_pkg::PMAX)
                                                              : PW'(sum_y[65:40]);
            end else if (k == tcd_pkg::ST_RECIP) begin
                prod_x = PRW'(p.pc_x) * PRW'(tcd_pkg::RECIP);
                prod_y = PRW'(p.pc_y) * PRW'(tcd_pkg::RECIP);
                p.q_x  = 17'(prod_x >> tcd_pkg::RSH);
                p.q_y  = 17'(prod_y >> tcd_pkg::RSH);
            end else if (k == tcd_pkg::ST_CORR) begin
                r_x = (PW+1)'(p.pc_x)
                    - (PW+1)'(p.q_x) * (PW+1)'(tcd_pkg::UPDATE_RATE);
                r_y = (PW+1)'(p.pc_y)
                    - (PW+1)'(p.q_y) * (PW+1)'(tcd_pkg::UPDATE_RATE);
                if (r_x >= (PW+1)'(tcd_pkg::UPDATE_RATE)) p.q_x = p.q_x + 17'd1;
                if (r_y >= (PW+1)'(tcd_pkg::UPDATE_RATE)) p.q_y = p.q_y + 17'd1;
            end else begin
                if (p.dead) begin
                    p.out_x = '0;
                    p.out_y = '0;
                end else begin
                    if (p.neg_x) p.out_x = (p.q_x > 17'd32768) ? 16'h8000
                                                                : 16'(17'd0 - p.q_x);
                    else         p.out_x = (p.q_x > 17'd32767) ? 16'h7fff : p.q_x[15:0];
                    if (p.neg_y) p.out_y = (p.q_y > 17'd32768) ? 16'h8000
                                                                : 16'(17'd0 - p.q_y);
                    else         p.out_y = (p.q_y > 17'd32767) ? 16'h7fff : p.q_y[15:0];
                end
            end
            pipe_next[k] = p;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (adv[k]) valid_reg[k] <= (k == 0) ? s_tvalid : valid_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NST; k++) begin
            if (adv[k]) pipe_reg[k] <= pipe_next[k];
        end
    end

    assign m_tvalid = valid_reg[NST-1];
    assign m_tdata  = {pipe_reg[NST-1].out_y, pipe_reg[NST-1].out_x};

`ifndef SYNTHESIS
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[NST-1] |-> s_tready)
        else $error("input stalled with empty output stage");

    a_sqrt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[tcd_pkg::ST_DIVINIT-1] |->
        48'(48'(pipe_reg[tcd_pkg::ST_DIVINIT-1].root) *
            48'(pipe_reg[tcd_pkg::ST_DIVINIT-1].root))
        <= {pipe_reg[tcd_pkg::ST_DIVINIT-1].lsq, 16'd0})
        else $error("square root overshoots");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[tcd_pkg::ST_LOOKUP-1] && !pipe_reg[tcd_pkg::ST_LOOKUP-1].capped |->
        pipe_reg[tcd_pkg::ST_LOOKUP-1].drem < 25'({15'd32767 - dz_reg, 8'd0}))
        else $error("divider remainder not reduced");

    a_rate_div: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[tcd_pkg::ST_CORR] |->
        (PW+2)'(pipe_reg[tcd_pkg::ST_CORR].q_x) * (PW+2)'(tcd_pkg::UPDATE_RATE)
        <= (PW+2)'(pipe_reg[tcd_pkg::ST_CORR].pc_x))
        else $error("rate quotient too large");
`endif

endmodule
`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives stick samples through the thumbstick cursor delta block with random
// gaps and back-pressure, predicts every cursor step in fixed point and checks
// each result transfer against it; register settings change between phases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] lx, ly, rx, ry;
        logic        boost;
    } sample_t;

    typedef struct {
        logic [15:0] mx, my;
    } step_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    thumbstick_cursor_delta_top dut (.*);

    initial forever #1 aclk = ~aclk;

    // predictor copy of the registers
    logic [14:0] dz_r;
    logic [15:0] speed_r, boostf_r;
    logic        swap_r;

    sample_t pending[$];
    step_t   expected_steps[$];
    int      errors = 0;
    bit      cfg_busy = 0;

    const longint unsigned EXPV[33] = '{442, 516, 604, 706, 825, 964, 1128, 1318, 1541,
        1802, 2107, 2463, 2879, 3366, 3936, 4601, 5379, 6289, 7353, 8596, 10050,
        11750, 13737, 16060, 18776, 21952, 25664, 30004, 35079, 41011, 47947,
        56056, 65536};

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] axis_step(longint a, longint unsigned sc,
                                              longint unsigned dv);
        longint unsigned mag, q;
        longint s;
        mag = (a < 0) ? -a : a;
        q = (mag * sc) / dv;
        if (a < 0) s = (q > 32768) ? -32768 : -longint'(q);
        else s = (q > 32767) ? 32767 : longint'(q);
        return s[15:0];
    endfunction

    function automatic step_t cursor_step(sample_t it);
        step_t r;
        longint tx, ty;
        longint unsigned lsq, dz, s8, num, den, m, b, idx, frac, e, c, sc;
        tx = swap_r ? longint'($signed(it.rx)) : longint'($signed(it.lx));
        ty = swap_r ? longint'($signed(it.ry)) : longint'($signed(it.ly));
        lsq = tx * tx + ty * ty;
        dz = 64'(dz_r);
        r.mx = '0;
        r.my = '0;
        if (lsq <= dz * dz) return r;
        s8 = int_sqrt(lsq << 16);
        num = s8 - dz * 256;
        den = (32767 - dz) * 256;
        if (den == 0) m = 65536;
        else begin
            m = (num << 16) / den;
            if (m > 65536) m = 65536;
        end
        idx = m >> 11;
        if (idx >= 32) e = EXPV[32];
        else begin
            frac = m & 2047;
            e = EXPV[idx] + (((EXPV[idx + 1] - EXPV[idx]) * frac) >> 11);
        end
        c = (m >> 2) + e - EXPV[0];
        b = (it.boost && boostf_r != 16'd0) ? 64'(boostf_r) : 64'd256;
        sc = c * 64'(speed_r) * b;
        r.mx = axis_step(tx, sc, longint'(tcd_pkg::UPDATE_RATE) << 40);
        r.my = axis_step(-ty, sc, longint'(tcd_pkg::UPDATE_RATE) << 40);
        return r;
    endfunction

    function automatic int gap_len();
        int p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // driver
    int s_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_steps.insert(expected_steps.size(),
                                      cursor_step(pending.pop_front()));
                s_gap = gap_len();
            end
            if ((!s_tvalid || s_tready) && s_gap > 0) begin
                s_gap--;
                s_tvalid <= 0;
            end else if (!s_tvalid || s_tready) begin
                if (pending.size() > 0 && !cfg_busy) begin
                    s_tvalid <= 1;
                    s_tdata <= {pending[0].ry, pending[0].rx, pending[0].ly, pending[0].lx};
                    s_tuser <= pending[0].boost;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // monitor
    int m_gap = 0;
    step_t x_exp;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_steps.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    x_exp = expected_steps.pop_front();
                    if (m_tdata[15:0] !== x_exp.mx) begin
                        $error("move_x expected %0d got %0d", $signed(x_exp.mx),
                               $signed(m_tdata[15:0]));
                        errors++;
                    end
                    if (m_tdata[31:16] !== x_exp.my) begin
                        $error("move_y expected %0d got %0d", $signed(x_exp.my),
                               $signed(m_tdata[31:16]));
                        errors++;
                    end
                end
                m_gap = gap_len();
            end
            if (m_gap > 0) begin
                m_gap--;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic write_reg(tcd_pkg::cfg_idx_t idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            tcd_pkg::CFG_DEAD_ZONE:    dz_r = val[14:0];
            tcd_pkg::CFG_CURSOR_SPEED: speed_r = val;
            tcd_pkg::CFG_BOOST_FACTOR: boostf_r = val;
            tcd_pkg::CFG_SWAP_STICKS:  swap_r = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending.size() > 0 || expected_steps.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (tcd_pkg::NST + 10) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 2000)) ^ {16{$urandom_range(0, 1) == 1}};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add(logic [15:0] lx, ly, rx, ry, logic b);
        sample_t it;
        it.lx = lx; it.ly = ly; it.rx = rx; it.ry = ry; it.boost = b;
        pending.insert(pending.size(), it);
    endtask

    task automatic random_phase(int n);
        repeat (n) add(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                       1'($urandom));
        drain();
    endtask

    initial begin
        dz_r = 15'd6000; speed_r = 16'd328; boostf_r = 16'd256; swap_r = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        // directed: extremes, dead zone edge, diagonals, boost, swap
        add(16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 1'b0);
        add(16'd6000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        add(16'd6001, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        add(16'h7fff, 16'h0000, 16'h8000, 16'h8000, 1'b0);
        add(16'h8000, 16'h8000, 16'h0001, 16'h0001, 1'b1);
        add(16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 1'b1);
        add(16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b0);
        add(16'h0000, 16'h7fff, 16'hffff, 16'hffff, 1'b1);
        drain();
        cfg_busy = 1;
        write_reg(tcd_pkg::CFG_CURSOR_SPEED, 16'hffff);
        write_reg(tcd_pkg::CFG_BOOST_FACTOR, 16'hffff);
        write_reg(tcd_pkg::CFG_SWAP_STICKS, 16'd1);
        write_reg(tcd_pkg::CFG_DEAD_ZONE, 16'd0);
        cfg_busy = 0;
        add(16'h0000, 16'h0000, 16'h0001, 16'h0000, 1'b1);
        add(16'h0000, 16'h0000, 16'h8000, 16'h8000, 1'b1);
        add(16'h0000, 16'h0000, 16'h7fff, 16'h8000, 1'b0);
        add(16'h1234, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        drain();
        cfg_busy = 1;
        write_reg(tcd_pkg::CFG_DEAD_ZONE, 16'd32767);
        write_reg(tcd_pkg::CFG_BOOST_FACTOR, 16'd0);
        cfg_busy = 0;
        add(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 1'b1);
        add(16'h0000, 16'h0000, 16'h7fff, 16'h0001, 1'b1);
        add(16'h0000, 16'h0000, 16'h8000, 16'h8000, 1'b0);
        drain();
        random_phase(300);
        for (int ph = 0; ph < 5; ph++) begin
            cfg_busy = 1;
            write_reg(tcd_pkg::CFG_DEAD_ZONE,
                      ph == 0 ? 16'd32766 : 16'($urandom_range(0, 20000)));
            write_reg(tcd_pkg::CFG_CURSOR_SPEED, ph == 1 ? 16'd0 : 16'($urandom));
            write_reg(tcd_pkg::CFG_BOOST_FACTOR, ph == 2 ? 16'd0 : 16'($urandom));
            write_reg(tcd_pkg::CFG_SWAP_STICKS, 16'(ph % 2));
            cfg_busy = 0;
            random_phase(265);
        end
        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// File: files.f
rtl/tcd_pkg.sv
rtl/thumbstick_cursor_delta_top.sv
tb/testbench.sv
